// File: hw/rtl/hpt_pkg.sv
// shared constants and types for the homogeneous point transform
`timescale 1ns / 1ps
package hpt_pkg;

  // default formats
  localparam int COORD_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 12;

  // matrix row layout
  localparam int ROW_BITS  = 64;
  localparam int COEF_BITS = 16;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;
  localparam logic [1:0] REG_ROW_W = 2'd3;

  // identity matrix after reset
  localparam logic [ROW_BITS-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_BITS-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_BITS-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_BITS-1:0] ROW_W_RST = 64'h0100_0000_0000_0000;

  // per-point control carried beside the divider lanes
  typedef struct packed {
    logic       three_d;
    logic       w_zero;
    logic [2:0] neg;
  } ctl_t;

endpackage

// File: hw/rtl/hpt_if.sv
// point and result channel interfaces
`timescale 1ns / 1ps
interface hpt_in_if #(
  parameter int COORD_BITS = hpt_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  modport source (output valid, func, px, py, pz, input ready);
  modport sink   (input valid, func, px, py, pz, output ready);
endinterface

interface hpt_out_if #(
  parameter int COORD_BITS = hpt_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;
  logic signed [COORD_BITS-1:0] qz;
  logic                         w_zero;
  logic                         clipped;

  modport source (output valid, qx, qy, qz, w_zero, clipped, input ready);
  modport sink   (input valid, qx, qy, qz, w_zero, clipped, output ready);
endinterface

// File: hw/rtl/hpt_div.sv
// pipelined three-lane divider with rounding and saturation, one quotient bit per stage
`timescale 1ns / 1ps
module hpt_div #(
  parameter int COORD_BITS = hpt_pkg::COORD_BITS_DEF,
  parameter int SUM_W      = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SUM_W-1:0]   n0,
  input  logic [SUM_W-1:0]   n1,
  input  logic [SUM_W-1:0]   n2,
  input  logic [SUM_W-1:0]   den,
  input  hpt_pkg::ctl_t      ctl,
  hpt_out_if.source          out_pt
);

  localparam int F1 = COORD_BITS / 2 + 1;
  localparam int QB = COORD_BITS + F1;
  localparam int NW = SUM_W + F1;
  localparam int CW = SUM_W + QB + 1;

  logic                v_r    [0:QB];
  logic [NW-1:0]       rem_r  [0:QB][0:2];
  logic [QB-1:0]       quo_r  [0:QB][0:2];
  logic [2:0]          big_r  [0:QB];
  logic [SUM_W-1:0]    d_r    [0:QB];
  hpt_pkg::ctl_t       ctl_r  [0:QB];
  logic                en     [0:QB];
  logic                en_o;

  logic                      ov_r;
  logic [COORD_BITS-1:0]     qx_r, qy_r, qz_r;
  logic                      wz_r, clip_r;
  logic [COORD_BITS-1:0]     q_nxt [0:2];
  logic                      clip_nxt;

  logic [SUM_W-1:0] n_in [0:2];
  assign n_in[0] = n0;
  assign n_in[1] = n1;
  assign n_in[2] = n2;

  // stall chain, bubbles collapse
  assign en_o = !ov_r || out_pt.ready;
  assign en[QB] = !v_r[QB] || en_o;
  for (genvar s = 0; s < QB; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end
  assign in_ready = en[0];

  // first stage: scale numerators and flag quotients beyond the integer range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
  end
  for (genvar l = 0; l < 3; l++) begin : g_first
    always_ff @(posedge clk) begin
      if (en[0]) begin
        rem_r[0][l] <= NW'(n_in[l]) << F1;
        quo_r[0][l] <= '0;
        big_r[0][l] <= (CW'(n_in[l]) << F1) >= (CW'(den) << QB);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]   <= den;
      ctl_r[0] <= ctl;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        d_r[s]   <= d_r[s-1];
        ctl_r[s] <= ctl_r[s-1];
        big_r[s] <= big_r[s-1];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW-1:0] trial;
      logic          ge;
      assign trial = CW'(d_r[s-1]) << (QB - s);
      assign ge    = CW'(rem_r[s-1][l]) >= trial;
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s][l] <= ge ? rem_r[s-1][l] - NW'(trial) : rem_r[s-1][l];
          quo_r[s][l] <= quo_r[s-1][l] | (ge ? (QB'(1) << (QB - s)) : '0);
        end
      end
    end
  end

  // round half away from zero, saturate, apply sign
  always_comb begin
    logic [QB:0]   inc;
    logic [QB-1:0] rnd;
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic          sat;
    clip_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      inc = (QB+1)'(quo_r[QB][l]) + (QB+1)'(1);
      rnd = inc[QB:1];
      lim = ctl_r[QB].neg[l] ? (QB'(1) << (COORD_BITS - 1))
                             : ((QB'(1) << (COORD_BITS - 1)) - QB'(1));
      sat = big_r[QB][l] || (rnd > lim);
      mag = sat ? lim : rnd;
      q_nxt[l] = ctl_r[QB].neg[l] ? COORD_BITS'(QB'(0) - mag) : COORD_BITS'(mag);
      if (ctl_r[QB].w_zero || (l == 2 && !ctl_r[QB].three_d)) begin
        q_nxt[l] = '0;
      end else if (sat) begin
        clip_nxt = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en_o) begin
      ov_r <= v_r[QB];
    end
  end
  always_ff @(posedge clk) begin
    if (en_o) begin
      qx_r   <= q_nxt[0];
      qy_r   <= q_nxt[1];
      qz_r   <= q_nxt[2];
      wz_r   <= ctl_r[QB].w_zero;
      clip_r <= clip_nxt;
    end
  end

  assign out_pt.valid   = ov_r;
  assign out_pt.qx      = qx_r;
  assign out_pt.qy      = qy_r;
  assign out_pt.qz      = qz_r;
  assign out_pt.w_zero  = wz_r;
  assign out_pt.clipped = clip_r;

`ifndef SYNTHESIS
  // a zero w gives an all-zero point without the clip flag
  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && wz_r |-> qx_r == '0 && qy_r == '0 && qz_r == '0 && !clip_r)
    else $error("zero w result not cleared");

  // a two-dimensional point leaves the divider with z cleared
  a_twod: assert property (@(posedge clk) disable iff (!rst_n)
    en_o && v_r[QB] && !ctl_r[QB].three_d |=> qz_r == '0)
    else $error("z not cleared for a two-dimensional point");

  // back pressure reaches the input only when every stage is full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0] && v_r[QB] && ov_r && !out_pt.ready)
    else $error("divider stalled with a bubble");
`endif

endmodule

// File: hw/rtl/homogeneous_point_transform.sv
// top level: matrix registers, dot-product stages and the divider pipeline
`timescale 1ns / 1ps
// Homogeneous point transform: each point beat (func, px, py, pz) is multiplied by the
// 4x4 matrix in the row registers and divided by w, giving one result beat (qx, qy, qz,
// w_zero, clipped) per point, in order. A point is accepted every clock unless back
// pressure holds the pipe. The divider resolves one quotient bit per pipeline stage.
// Stages drain independently, so back pressure only stops the input once the pipe is
// full. The user must write rows through cfg_we/cfg_idx/cfg_data only while no point
// is in flight; the block itself does not enforce this.
module homogeneous_point_transform #(
  parameter int COORD_BITS     = hpt_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = hpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [hpt_pkg::ROW_BITS-1:0]  cfg_data,
  hpt_in_if.sink                        in_pt,
  hpt_out_if.source                     out_pt
);

  localparam int CB    = hpt_pkg::COEF_BITS;
  localparam int TS    = COORD_BITS / 2 + COEF_FRAC_BITS - 8;
  localparam int PW    = CB + COORD_BITS;
  localparam int TW    = CB + TS;
  localparam int SUM_W = ((PW > TW) ? PW : TW) + 2;

  logic [hpt_pkg::ROW_BITS-1:0] row_r [0:3];

  // matrix rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= hpt_pkg::ROW_X_RST;
      row_r[1] <= hpt_pkg::ROW_Y_RST;
      row_r[2] <= hpt_pkg::ROW_Z_RST;
      row_r[3] <= hpt_pkg::ROW_W_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hpt_pkg::REG_ROW_X: row_r[0] <= cfg_data;
        hpt_pkg::REG_ROW_Y: row_r[1] <= cfg_data;
        hpt_pkg::REG_ROW_Z: row_r[2] <= cfg_data;
        hpt_pkg::REG_ROW_W: row_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en_a, en_b, en_c, en_d, div_ready;
  logic va_r, vb_r, vc_r, vd_r;

  // stall chain
  assign en_d = !vd_r || div_ready;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_pt.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_pt.valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  // input beat, z dropped for a two-dimensional point
  logic                         td_a_r;
  logic signed [COORD_BITS-1:0] crd_a_r [0:2];
  always_ff @(posedge clk) begin
    if (en_a) begin
      td_a_r     <= in_pt.func;
      crd_a_r[0] <= in_pt.px;
      crd_a_r[1] <= in_pt.py;
      crd_a_r[2] <= in_pt.func ? in_pt.pz : '0;
    end
  end

  // coefficient products and scaled translations
  logic                    td_b_r;
  logic signed [PW-1:0]    prod_b_r [0:3][0:2];
  logic signed [SUM_W-1:0] tr_b_r   [0:3];
  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [CB-1:0] tr;
    assign tr = row_r[r][3*CB +: CB];
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [CB-1:0] cf;
      assign cf = row_r[r][c*CB +: CB];
      always_ff @(posedge clk) begin
        if (en_b) prod_b_r[r][c] <= PW'(cf) * PW'(crd_a_r[c]);
      end
    end
    always_ff @(posedge clk) begin
      if (en_b) tr_b_r[r] <= SUM_W'(tr) <<< TS;
    end
  end
  always_ff @(posedge clk) begin
    if (en_b) td_b_r <= td_a_r;
  end

  // row sums
  logic                    td_c_r;
  logic signed [SUM_W-1:0] sum_c_r [0:3];
  for (genvar r = 0; r < 4; r++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en_c) begin
        sum_c_r[r] <= SUM_W'(prod_b_r[r][0]) + SUM_W'(prod_b_r[r][1])
                    + SUM_W'(prod_b_r[r][2]) + tr_b_r[r];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en_c) td_c_r <= td_b_r;
  end

  // magnitudes and quotient signs
  logic [SUM_W-1:0] mag_d_r [0:3];
  hpt_pkg::ctl_t    ctl_d_r;
  hpt_pkg::ctl_t    ctl_nxt;
  always_comb begin
    ctl_nxt.three_d = td_c_r;
    ctl_nxt.w_zero  = sum_c_r[3] == '0;
    for (int l = 0; l < 3; l++) begin
      ctl_nxt.neg[l] = sum_c_r[l][SUM_W-1] ^ sum_c_r[3][SUM_W-1];
    end
  end
  for (genvar r = 0; r < 4; r++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en_d) begin
        mag_d_r[r] <= sum_c_r[r][SUM_W-1] ? SUM_W'(-sum_c_r[r]) : SUM_W'(sum_c_r[r]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en_d) ctl_d_r <= ctl_nxt;
  end

  hpt_div #(
    .COORD_BITS (COORD_BITS),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vd_r),
    .in_ready (div_ready),
    .n0       (mag_d_r[0]),
    .n1       (mag_d_r[1]),
    .n2       (mag_d_r[2]),
    .den      (mag_d_r[3]),
    .ctl      (ctl_d_r),
    .out_pt   (out_pt)
  );

`ifndef SYNTHESIS
  // back pressure stops the input only when every front stage is full and the divider stalls
  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    !en_a |-> va_r && vb_r && vc_r && vd_r && !div_ready)
    else $error("front stages stalled with a bubble");

  // a two-dimensional point reaches the product stage with z cleared
  a_zdrop: assert property (@(posedge clk) disable iff (!rst_n)
    en_a && in_pt.valid && !in_pt.func |=> crd_a_r[2] == '0)
    else $error("z kept for a two-dimensional point");

  // the w flag matches a zero magnitude at the divider input
  a_wflag: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r |-> ctl_d_r.w_zero == (mag_d_r[3] == '0))
    else $error("w flag out of step with w");
`endif

endmodule
